[rtl/mmcr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcr_pkg
// Shared constants and types for the Mueller-Muller timing recovery block.
// ----------------------------------------------------------------------------
package mmcr_pkg;
   localparam int NFILT      = 128;
   localparam int NTAPS      = 8;
   localparam int TABLE_SIZE = NFILT * NTAPS;
   localparam int TAB_AW     = $clog2(TABLE_SIZE);
   localparam int ROW_W      = $clog2(NFILT);
   localparam int TAP_W      = $clog2(NTAPS);
   localparam int IDX_W      = 10;
   localparam int CSR_AW     = 3;

   localparam logic [CSR_AW-1:0] REG_MODE      = 3'd0;
   localparam logic [CSR_AW-1:0] REG_OMEGA     = 3'd1;
   localparam logic [CSR_AW-1:0] REG_MU        = 3'd2;
   localparam logic [CSR_AW-1:0] REG_OMEGA_G   = 3'd3;
   localparam logic [CSR_AW-1:0] REG_MU_G      = 3'd4;
   localparam logic [CSR_AW-1:0] REG_LIMIT     = 3'd5;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TAP    = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic signed [15:0] sample_i;
      logic signed [15:0] sample_q;
      logic [IDX_W-1:0]   tap_index;
      logic signed [15:0] tap_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_i;
      logic signed [15:0] out_q;
   } rsp_type;

   typedef struct packed {
      logic [CSR_AW-1:0] index;
      logic [23:0]       data;
   } csr_type;

   function automatic logic signed [15:0] sat16(input logic signed [39:0] x);
      if (x > 40'sd32767) return 16'sh7FFF;
      if (x < -40'sd32768) return 16'sh8000;
      return x[15:0];
   endfunction
endpackage

[rtl/mmcr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcr_req_if / mmcr_rsp_if / mmcr_csr_if
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface mmcr_req_if;
   import mmcr_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface mmcr_rsp_if;
   import mmcr_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface mmcr_csr_if;
   import mmcr_pkg::*;
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/mmcr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcr_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module mmcr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[rtl/mmcr_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcr_mac
// Shared complex-by-real multiply-accumulate, one tap per cycle while enable is high.
// ----------------------------------------------------------------------------
module mmcr_mac
   import mmcr_pkg::*;
(
   input  logic               clock,
   input  logic               clear,
   input  logic               enable,
   input  logic signed [15:0] coef,
   input  logic signed [15:0] x_i,
   input  logic signed [15:0] x_q,
   output logic signed [39:0] acc_i,
   output logic signed [39:0] acc_q
);
   logic signed [39:0] acc_i_ff, acc_q_ff;

   always_ff @(posedge clock) begin
      if (clear) begin
         acc_i_ff <= '0;
         acc_q_ff <= '0;
      end else if (enable) begin
         acc_i_ff <= acc_i_ff + 40'(x_i * coef);
         acc_q_ff <= acc_q_ff + 40'(x_q * coef);
      end
   end

   assign acc_i = acc_i_ff;
   assign acc_q = acc_q_ff;
endmodule

[rtl/mueller_muller_clock_recovery.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mueller_muller_clock_recovery
// Mueller-Muller symbol timing recovery with a polyphase interpolator.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries sample requests (cmd 0) and tap writes (cmd 1). A tap write
//   or a skipped sample is handled in S_IDLE. A sample that yields a symbol
//   runs NTAPS multiply-accumulate steps on one shared MAC, fed by the
//   registered tap RAM read port, then rounding and loop update in S_ROUND,
//   S_ERR, S_OMEGA, S_MU and S_POST. The symbol is posted from S_POST, which
//   waits while an older symbol is untaken; no new request is taken until the
//   block is back in S_IDLE. Symbols come about once per omega/2^16 samples.
//   rsp_ carries symbols through an output register; the block accepts
//   further requests while a symbol waits, but stalls before posting a new
//   one until the old one is taken.
//   csr_ writes registers; it is always ready and must be used while idle.
//   Reset restores register defaults, clears history and loop state. Tap RAM
//   content is undefined until written.
// ----------------------------------------------------------------------------
module mueller_muller_clock_recovery
   import mmcr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mmcr_req_if.sink   req,
   mmcr_rsp_if.source rsp,
   mmcr_csr_if.sink   csr
);
   typedef enum logic [2:0] {S_IDLE, S_MAC, S_ROUND, S_ERR, S_OMEGA, S_MU, S_POST}
      state_type;

   state_type state_ff;
   logic mode_ff;
   logic [23:0] omega_init_ff, omega_ff;
   logic [15:0] mu_ff, og_ff, mg_ff, lim_rel_ff;
   logic signed [15:0] hi_ff [NTAPS];
   logic signed [15:0] hq_ff [NTAPS];
   logic signed [15:0] p1i_ff, p1q_ff, p2i_ff, p2q_ff, yi_ff, yq_ff;
   logic [3:0] dec_ff;
   logic [7:0] skip_ff;
   logic [TAP_W:0] k_ff;
   logic [ROW_W-1:0] row_ff;
   logic signed [17:0] err_ff;
   logic signed [25:0] omega_w_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   // tap RAM
   logic [TAB_AW-1:0] rd_addr;
   logic [15:0] rd_data;
   logic wr_en;
   assign wr_en = req.valid && req.ready && req.data.cmd == CMD_TAP &&
                  {1'b0, req.data.tap_index} < (IDX_W+1)'(TABLE_SIZE);
   assign rd_addr = TAB_AW'({row_ff, k_ff[TAP_W-1:0]});

   mmcr_ram #(.WIDTH(16), .DEPTH(TABLE_SIZE)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(req.data.tap_index[TAB_AW-1:0]),
      .wr_data(req.data.tap_value), .rd_addr(rd_addr), .rd_data(rd_data));

   // MAC: data from RAM arrives in the cycle after its address
   logic mac_clr, mac_en;
   logic [TAP_W:0] kd_ff;
   logic signed [39:0] acc_i, acc_q;
   assign mac_clr = state_ff == S_IDLE;
   assign mac_en  = state_ff == S_MAC && k_ff != '0;
   mmcr_mac u_mac (
      .clock(clock), .clear(mac_clr), .enable(mac_en), .coef(rd_data),
      .x_i(hi_ff[kd_ff[TAP_W-1:0]]), .x_q(hq_ff[kd_ff[TAP_W-1:0]]),
      .acc_i(acc_i), .acc_q(acc_q));

   assign req.ready = state_ff == S_IDLE;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // row select: round(mu*NFILT) clamped
   logic [16+ROW_W:0] row_full;
   assign row_full = ((17+ROW_W)'(mu_ff) * (17+ROW_W)'(NFILT) + (17+ROW_W)'(32768)) >> 16;

   // error terms (combinational on registered values)
   logic c0i, c0q;
   logic signed [18:0] err_c, err_r;
   logic signed [17:0] err_clip;
   logic signed [16:0] sy, sp;
   always_comb begin
      c0i = yi_ff > 0;
      c0q = yq_ff > 0;
      err_c = (dec_ff[0] ? 19'(yi_ff) - 19'(p2i_ff) : 19'sd0)
            + (dec_ff[1] ? 19'(yq_ff) - 19'(p2q_ff) : 19'sd0)
            - 19'(($signed({1'b0, c0i}) - $signed({1'b0, dec_ff[2]})) * p1i_ff)
            - 19'(($signed({1'b0, c0q}) - $signed({1'b0, dec_ff[3]})) * p1q_ff);
      sy = p1i_ff < 0 ? -17'(yi_ff) : 17'(yi_ff);
      sp = yi_ff < 0 ? -17'(p1i_ff) : 17'(p1i_ff);
      err_r = 19'(sy) - 19'(sp);
      if (mode_ff) err_clip = (err_c > 19'sd32768) ? 18'sd32768 :
                              (err_c < -19'sd32768) ? -18'sd32768 : 18'(err_c);
      else         err_clip = (err_r > 19'sd32768) ? 18'sd32768 :
                              (err_r < -19'sd32768) ? -18'sd32768 : 18'(err_r);
   end

   logic signed [34:0] og_prod, mg_prod;
   logic signed [25:0] og_term, mg_term;
   logic [40:0] lim_prod;
   logic signed [25:0] lim, dev, om_c;
   logic signed [27:0] total;
   always_comb begin
      og_prod = $signed({1'b0, og_ff}) * err_ff + 35'sd16384;
      og_term = 26'(og_prod >>> 15);
      mg_prod = $signed({1'b0, mg_ff}) * err_ff + 35'sd16384;
      mg_term = 26'(mg_prod >>> 15);
      lim_prod = 41'(lim_rel_ff) * 41'(omega_init_ff) + 41'd32768;
      lim = 26'(lim_prod >> 16);
      dev = omega_w_ff - $signed({2'b0, omega_init_ff});
      if (dev > lim) dev = lim;
      else if (dev < -lim) dev = -lim;
      om_c = $signed({2'b0, omega_init_ff}) + dev;
      if (om_c < 26'sd65536) om_c = 26'sd65536;
      if (om_c > 26'sd16777215) om_c = 26'sd16777215;
      total = 28'($signed({1'b0, mu_ff})) + 28'($signed({1'b0, omega_ff})) + 28'(mg_term);
      if (total < 0) total = '0;
   end

   logic [11:0] adv;
   assign adv = (total[27:16] == '0) ? 12'd1 :
                (total[27:16] > 12'd256) ? 12'd256 : total[27:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= 1'b1;
         omega_init_ff <= 24'd131072;
         omega_ff <= 24'd131072;
         mu_ff <= 16'd32768;
         og_ff <= 16'd16;
         mg_ff <= 16'd1311;
         lim_rel_ff <= 16'd328;
         for (int j = 0; j < NTAPS; j++) begin
            hi_ff[j] <= '0;
            hq_ff[j] <= '0;
         end
         p1i_ff <= '0; p1q_ff <= '0; p2i_ff <= '0; p2q_ff <= '0;
         dec_ff <= '0;
         skip_ff <= '0;
         k_ff <= '0;
         kd_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in S_POST the post logic below owns the valid flag
         if (rsp.valid && rsp.ready && state_ff != S_POST) rsp_valid_ff <= 1'b0;
         if (csr.valid) begin
            case (csr.data.index)
               REG_MODE:    mode_ff <= csr.data.data[0];
               REG_OMEGA:   begin omega_init_ff <= csr.data.data; omega_ff <= csr.data.data; end
               REG_MU:      mu_ff <= csr.data.data[15:0];
               REG_OMEGA_G: og_ff <= csr.data.data[15:0];
               REG_MU_G:    mg_ff <= csr.data.data[15:0];
               REG_LIMIT:   lim_rel_ff <= csr.data.data[15:0];
               default: ;
            endcase
         end
         kd_ff <= k_ff;
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.data.cmd == CMD_SAMPLE) begin
                  for (int j = 0; j < NTAPS - 1; j++) begin
                     hi_ff[j] <= hi_ff[j+1];
                     hq_ff[j] <= hq_ff[j+1];
                  end
                  hi_ff[NTAPS-1] <= req.data.sample_i;
                  hq_ff[NTAPS-1] <= req.data.sample_q;
                  if (skip_ff != '0) skip_ff <= skip_ff - 8'd1;
                  else begin
                     row_ff <= (row_full > (17+ROW_W)'(NFILT-1)) ? ROW_W'(NFILT-1)
                                                                 : row_full[ROW_W-1:0];
                     k_ff <= '0;
                     state_ff <= S_MAC;
                  end
               end
            end
            S_MAC: begin
               // address k while accumulating k-1
               if (k_ff == (TAP_W+1)'(NTAPS)) state_ff <= S_ROUND;
               else k_ff <= k_ff + 1'b1;
            end
            S_ROUND: begin
               k_ff <= '0;
               yi_ff <= sat16((acc_i + 40'sd8192) >>> 14);
               yq_ff <= mode_ff ? sat16((acc_q + 40'sd8192) >>> 14) : 16'sd0;
               state_ff <= S_ERR;
            end
            S_ERR: begin
               err_ff <= err_clip;
               dec_ff <= mode_ff ? {dec_ff[1:0], c0q, c0i} : 4'd0;
               p2i_ff <= p1i_ff; p2q_ff <= p1q_ff;
               p1i_ff <= yi_ff;  p1q_ff <= yq_ff;
               state_ff <= S_OMEGA;
            end
            S_OMEGA: begin
               omega_w_ff <= $signed({2'b0, omega_ff}) + og_term;
               state_ff <= S_MU;
            end
            S_MU: begin
               omega_ff <= om_c[23:0];
               state_ff <= S_POST;
            end
            S_POST: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  mu_ff <= total[15:0];
                  skip_ff <= 8'(adv - 12'd1);
                  rsp_ff.out_i <= p1i_ff;
                  rsp_ff.out_q <= p1q_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
